// ----- sv/signed_decimal_formatter_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the signed decimal formatter
// Shared property forms with the clock and reset of the checked block.
// ----------------------------------------------------------------------------
`ifndef SIGNED_DECIMAL_FORMATTER_MACROS_SVH
`define SIGNED_DECIMAL_FORMATTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SDF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("signed decimal formatter check failed");

// Next-cycle implication, checked outside reset.
`define SDF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("signed decimal formatter check failed");

`endif

// ----- sv/sdf_pkg.sv -----
// ----------------------------------------------------------------------------
// sdf_pkg
// Types and constants of the signed decimal formatter.
// ----------------------------------------------------------------------------
package sdf_pkg;

  // Input word layout: value, flags, minimum width, from the lowest bit up.
  localparam int IN_VALUE_W = 64;
  localparam int IN_FLAGS_W = 3;
  localparam int IN_WIDTH_W = 6;
  localparam int IN_DATA_W  = 80;
  localparam int IN_FLAGS_LO = IN_VALUE_W;
  localparam int IN_WIDTH_LO = IN_VALUE_W + IN_FLAGS_W;

  localparam int CHAR_W = 8;

  // Flag bit positions.
  localparam int FLAG_ZERO  = 0;
  localparam int FLAG_PLUS  = 1;
  localparam int FLAG_SPACE = 2;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ     = 4'd3;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_NORM = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

endpackage

// ----- sv/signed_decimal_formatter.sv -----
// ----------------------------------------------------------------------------
// signed_decimal_formatter
// Formats a signed integer as printf-style decimal text, one character per
// output word, with sign, space or zero padding to a minimum width.
// ----------------------------------------------------------------------------
//  Channel  Dir  Word contents (low bit first)                 Marker
//  s_*      in   value[63:0], format_flags[2:0], min_width[5:0] -
//  m_*      out  out_char[7:0]                                  tlast = last_char
//
// One number takes an accept step, binary-to-BCD conversion of VALUE_BITS
// bits through the shared dabble step, stripping of up to DIGITS-1 leading
// zeros plus a setup step, then one character per cycle (at most MAX_WIDTH,
// or the text length) while m_tready is high. s_tready is high only while
// the sequencer is idle. Output stalls hold the character register and
// pause emission. rst is synchronous, active high.
// ----------------------------------------------------------------------------
module signed_decimal_formatter #(
  parameter int MAX_WIDTH  = 63,
  parameter int VALUE_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // value [63:0], format_flags [66:64], min_width [72:67], zero fill above
  input  logic [sdf_pkg::IN_DATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // out_char [7:0]
  output logic [sdf_pkg::CHAR_W-1:0]    m_tdata,
  output logic                          m_tlast
);

  localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_W  = 4 * DIGITS;
  localparam int NDW    = $clog2(DIGITS + 1);
  localparam int BCW    = $clog2(VALUE_BITS);
  localparam int WW     = sdf_pkg::IN_WIDTH_W;

  sdf_pkg::state_t state;

  logic [VALUE_BITS-1:0] mag;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_next;
  logic [BCW-1:0]        bit_cnt;
  logic [NDW-1:0]        nd;
  logic                  sign_en;
  logic [7:0]            sign_char;
  logic                  zero_mode;
  logic [WW-1:0]         width_sat;
  logic [WW-1:0]         pad;
  logic [WW-1:0]         pre;
  logic [WW-1:0]         last_pos;
  logic [WW-1:0]         pos;

  logic [VALUE_BITS-1:0] in_value;
  logic [2:0]            in_flags;
  logic [WW-1:0]         in_width;
  logic                  in_neg;
  logic [3:0]            top_digit;
  logic [WW-1:0]         len;
  logic [7:0]            ch;
  logic                  ch_is_digit;
  logic                  emit;
  logic                  accept;

  assign in_value = s_tdata[VALUE_BITS-1:0];
  assign in_flags = s_tdata[sdf_pkg::IN_FLAGS_LO +: sdf_pkg::IN_FLAGS_W];
  assign in_width = s_tdata[sdf_pkg::IN_WIDTH_LO +: sdf_pkg::IN_WIDTH_W];
  assign in_neg   = in_value[VALUE_BITS-1];

  assign s_tready  = (state == sdf_pkg::ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign top_digit = bcd[BCD_W-1 -: 4];
  assign len       = WW'(nd) + WW'(sign_en);
  assign emit      = (state == sdf_pkg::ST_EMIT) && (!m_tvalid || m_tready);

  sdf_dabble #(
    .DIGITS (DIGITS)
  ) u_dabble (
    .bcd      (bcd),
    .bit_in   (mag[VALUE_BITS-1]),
    .bcd_next (bcd_next)
  );

  // Character at the current position: pad and sign ahead of the digits.
  always_comb begin
    ch          = sdf_pkg::CH_ZERO + {4'd0, top_digit};
    ch_is_digit = 1'b0;
    if (zero_mode) begin
      if (sign_en && pos == '0) begin
        ch = sign_char;
      end else if (pos < pre) begin
        ch = sdf_pkg::CH_ZERO;
      end else begin
        ch_is_digit = 1'b1;
      end
    end else begin
      if (pos < pad) begin
        ch = sdf_pkg::CH_SPACE;
      end else if (pos < pre) begin
        ch = sign_char;
      end else begin
        ch_is_digit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sdf_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        sdf_pkg::ST_IDLE: begin
          if (accept) begin
            state <= sdf_pkg::ST_CONV;
          end
        end
        sdf_pkg::ST_CONV: begin
          if (bit_cnt == '0) begin
            state <= sdf_pkg::ST_NORM;
          end
        end
        sdf_pkg::ST_NORM: begin
          if (!(top_digit == 4'd0 && nd > NDW'(1))) begin
            state <= sdf_pkg::ST_EMIT;
          end
        end
        sdf_pkg::ST_EMIT: begin
          if (emit && pos == last_pos) begin
            state <= sdf_pkg::ST_IDLE;
          end
        end
        default: state <= sdf_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= ch;
      m_tlast <= (pos == last_pos);
    end
    unique case (state)
      sdf_pkg::ST_IDLE: begin
        // The magnitude of the most negative value comes out right as unsigned.
        mag       <= in_neg ? (~in_value + VALUE_BITS'(1)) : in_value;
        bcd       <= '0;
        bit_cnt   <= BCW'(VALUE_BITS - 1);
        nd        <= NDW'(DIGITS);
        sign_en   <= in_neg || in_flags[sdf_pkg::FLAG_PLUS] || in_flags[sdf_pkg::FLAG_SPACE];
        sign_char <= in_neg ? sdf_pkg::CH_MINUS :
                     in_flags[sdf_pkg::FLAG_PLUS] ? sdf_pkg::CH_PLUS : sdf_pkg::CH_SPACE;
        zero_mode <= in_flags[sdf_pkg::FLAG_ZERO];
        width_sat <= (in_width > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : in_width;
      end
      sdf_pkg::ST_CONV: begin
        bcd     <= bcd_next;
        mag     <= {mag[VALUE_BITS-2:0], 1'b0};
        bit_cnt <= bit_cnt - BCW'(1);
      end
      sdf_pkg::ST_NORM: begin
        if (top_digit == 4'd0 && nd > NDW'(1)) begin
          bcd <= {bcd[BCD_W-5:0], 4'd0};
          nd  <= nd - NDW'(1);
        end else begin
          pad      <= (width_sat > len) ? (width_sat - len) : '0;
          pre      <= (width_sat > len) ? (width_sat - WW'(nd)) : WW'(sign_en);
          last_pos <= ((width_sat > len) ? width_sat : len) - WW'(1);
          pos      <= '0;
        end
      end
      sdf_pkg::ST_EMIT: begin
        if (emit) begin
          pos <= pos + WW'(1);
          if (ch_is_digit) begin
            bcd <= {bcd[BCD_W-5:0], 4'd0};
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/sdf_dabble.sv -----
// ----------------------------------------------------------------------------
// sdf_dabble
// One double-dabble step: add three to every BCD digit of five or more, then
// shift the whole digit string left by one bit, taking in the next binary bit.
// ----------------------------------------------------------------------------
module sdf_dabble #(
  parameter int DIGITS = 20
) (
  input  logic [4*DIGITS-1:0] bcd,
  input  logic                bit_in,
  output logic [4*DIGITS-1:0] bcd_next
);

  logic [4*DIGITS-1:0] adjusted;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] >= sdf_pkg::BCD_ADJ_MIN) begin
        adjusted[4*i +: 4] = bcd[4*i +: 4] + sdf_pkg::BCD_ADJ;
      end else begin
        adjusted[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  assign bcd_next = {adjusted[4*DIGITS-2:0], bit_in};

endmodule

// ----- sv/sdf_checker.sv -----
// ----------------------------------------------------------------------------
// sdf_checker
// Port-level checks of the signed decimal formatter, bound to the top level.
// ----------------------------------------------------------------------------
`include "signed_decimal_formatter_macros.svh"

module sdf_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // A number in work blocks the input from its acceptance on.
  `SDF_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

  // While a non-final character waits, the field is not done yet.
  `SDF_ASSERT_NOW(a_busy_mid_field, m_tvalid && !m_tlast, !s_tready)

  // Only digits, sign characters and space ever appear.
  `SDF_ASSERT_NOW(a_char_set, m_tvalid, (m_tdata >= 8'h30 && m_tdata <= 8'h39) ||
    m_tdata == 8'h2D || m_tdata == 8'h2B || m_tdata == 8'h20)

  // A stalled word holds.
  `SDF_ASSERT_NEXT(a_hold_on_stall, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind signed_decimal_formatter sdf_checker u_sdf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
